// File: rtl/prefix_code_archive_decoder_macros.svh
// Assertion helpers for the prefix code archive decoder.
`ifndef PREFIX_CODE_ARCHIVE_DECODER_MACROS_SVH
`define PREFIX_CODE_ARCHIVE_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCAD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcad assertion failed");
`define PCAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcad assertion failed");
`else
`define PCAD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PCAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/pcad_pkg.sv
// ----------------------------------------------------------------------------
// pcad_pkg
// Shared types and constants of the prefix code archive decoder.
// ----------------------------------------------------------------------------
package pcad_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int TABLE_SLOTS  = 256;
  localparam int SYM_W        = $clog2(TABLE_SLOTS);
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int CODE_W       = MAX_CODE_LEN;

  typedef enum logic [1:0] {
    ST_SYMBOL   = 2'd0,
    ST_OVERLONG = 2'd1,
    ST_NOMATCH  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SYM, PH_LEN, PH_BITS, PH_TOTAL, PH_DATA, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    S_IN, S_BITS, S_FLUSH
  } seq_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    status_e    status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic              clear;
    logic              wr;
    logic [SYM_W-1:0]  wr_sym;
    logic [LEN_W-1:0]  wr_len;
    logic [CODE_W-1:0] wr_bits;
  } cell_ctl_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } cmp_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
    status_e          status;
  } pend_t;

endpackage

// File: rtl/prefix_code_archive_decoder.sv
// ----------------------------------------------------------------------------
// prefix_code_archive_decoder
// Parses a prefix code table and decodes the data bits of an archive.
// ----------------------------------------------------------------------------
// A header or table byte is taken in S_IN; a data byte is accepted there,
// then its data bits (up to eight) are matched one by one in S_BITS, then
// S_FLUSH hands over the held result; no new byte is taken before then.
// Each bit is matched against all table cells in the same cycle.
// Reset clears the phase, every counter but the bit index, and every table length (no entries).
// ----------------------------------------------------------------------------
`include "prefix_code_archive_decoder_macros.svh"

module prefix_code_archive_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcad_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcad_pkg::out_item_t out_data_o
);
  import pcad_pkg::*;

  phase_e            phase_q, phase_d;
  seq_e              st_q, st_d;
  logic [7:0]        entries_left_q, entries_left_d;
  logic [SYM_W-1:0]  entry_sym_q, entry_sym_d;
  logic [LEN_W-1:0]  entry_len_q, entry_len_d;
  logic [LEN_W-1:0]  entry_done_q, entry_done_d;
  logic [CODE_W-1:0] entry_code_q, entry_code_d;
  logic [63:0]       total_q, total_d;
  logic [2:0]        cnt_idx_q, cnt_idx_d;
  logic [63:0]       remain_q, remain_d;
  logic [CODE_W-1:0] buf_q, buf_d;
  logic [LEN_W-1:0]  mlen_q, mlen_d;
  logic [7:0]        byte_q, byte_d;
  logic [2:0]        bit_q, bit_d;
  pend_t             pend_q, pend_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  cell_ctl_t         cell_ctl;
  cmp_t              cmp;
  logic              hit_any;
  logic [SYM_W-1:0]  hit_sym;

  logic              out_free;
  logic              push;
  out_item_t         push_item;
  pend_t             res;
  logic              blocked;
  logic [LEN_W-1:0]  done_n;
  logic [CODE_W-1:0] code_n;
  logic [7:0]        el_n;
  logic [7:0]        in_byte;

  assign in_byte  = in_data_i.data_byte;
  assign out_free = !out_valid_q || out_ready_i;

  // next buffer content is compared against every cell
  assign cmp.bits = {buf_q[CODE_W-2:0], byte_q[3'd7 - bit_q]};
  assign cmp.len  = mlen_q + LEN_W'(1);

  pcad_cell_array u_cells (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (cell_ctl),
    .cmp_i    (cmp),
    .hit_any_o(hit_any),
    .hit_sym_o(hit_sym)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      st_q           <= S_IN;
      entries_left_q <= '0;
      entry_sym_q    <= '0;
      entry_len_q    <= '0;
      entry_done_q   <= '0;
      entry_code_q   <= '0;
      total_q        <= '0;
      cnt_idx_q      <= '0;
      remain_q       <= '0;
      buf_q          <= '0;
      mlen_q         <= '0;
      pend_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      st_q           <= st_d;
      entries_left_q <= entries_left_d;
      entry_sym_q    <= entry_sym_d;
      entry_len_q    <= entry_len_d;
      entry_done_q   <= entry_done_d;
      entry_code_q   <= entry_code_d;
      total_q        <= total_d;
      cnt_idx_q      <= cnt_idx_d;
      remain_q       <= remain_d;
      buf_q          <= buf_d;
      mlen_q         <= mlen_d;
      pend_q         <= pend_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  always_comb begin
    phase_d        = phase_q;
    st_d           = st_q;
    entries_left_d = entries_left_q;
    entry_sym_d    = entry_sym_q;
    entry_len_d    = entry_len_q;
    entry_done_d   = entry_done_q;
    entry_code_d   = entry_code_q;
    total_d        = total_q;
    cnt_idx_d      = cnt_idx_q;
    remain_d       = remain_q;
    buf_d          = buf_q;
    mlen_d         = mlen_q;
    byte_d         = byte_q;
    bit_d          = bit_q;
    pend_d         = pend_q;
    cell_ctl       = '0;
    push           = 1'b0;
    push_item      = '0;
    res            = '0;
    blocked        = 1'b0;
    el_n           = entries_left_q - 8'd1;

    // gather up to eight code bits of this byte, MSB first
    code_n = entry_code_q;
    done_n = entry_done_q;
    for (int b = 0; b < 8; b++) begin
      if (done_n < entry_len_q) begin
        code_n = {code_n[CODE_W-2:0], in_byte[7-b]};
        done_n = done_n + LEN_W'(1);
      end
    end

    unique case (st_q)
      S_IN: begin
        if (in_valid_i) begin
          if (in_data_i.start_flag) begin
            // open a new archive: drop the table, load the entry count, clear the total and data counters
            cell_ctl.clear = 1'b1;
            entries_left_d = in_byte;
            total_d        = '0;
            cnt_idx_d      = '0;
            remain_d       = '0;
            buf_d          = '0;
            mlen_d         = '0;
            phase_d        = (in_byte != 8'd0) ? PH_SYM : PH_TOTAL;
          end else begin
            unique case (phase_q)
              PH_SYM: begin
                entry_sym_d = in_byte;
                phase_d     = PH_LEN;
              end
              PH_LEN: begin
                entry_done_d = '0;
                entry_code_d = '0;
                if (in_byte > 8'(MAX_CODE_LEN)) begin
                  pend_d  = '{valid: 1'b1, sym: '0, status: ST_OVERLONG};
                  phase_d = PH_DONE;
                  st_d    = S_FLUSH;
                end else if (in_byte == 8'd0) begin
                  // zero length removes the symbol
                  cell_ctl.wr     = 1'b1;
                  cell_ctl.wr_sym = entry_sym_q;
                  entries_left_d  = el_n;
                  if (el_n != 8'd0) begin
                    phase_d = PH_SYM;
                  end else begin
                    phase_d   = PH_TOTAL;
                    cnt_idx_d = '0;
                    total_d   = '0;
                  end
                end else begin
                  entry_len_d = in_byte[LEN_W-1:0];
                  phase_d     = PH_BITS;
                end
              end
              PH_BITS: begin
                entry_code_d = code_n;
                entry_done_d = done_n;
                if (done_n >= entry_len_q) begin
                  cell_ctl.wr      = 1'b1;
                  cell_ctl.wr_sym  = entry_sym_q;
                  cell_ctl.wr_len  = entry_len_q;
                  cell_ctl.wr_bits = code_n;
                  entries_left_d   = el_n;
                  if (el_n != 8'd0) begin
                    phase_d = PH_SYM;
                  end else begin
                    phase_d   = PH_TOTAL;
                    cnt_idx_d = '0;
                    total_d   = '0;
                  end
                end
              end
              PH_TOTAL: begin
                total_d[cnt_idx_q*8 +: 8] = in_byte;
                cnt_idx_d = cnt_idx_q + 3'd1;
                if (cnt_idx_q == 3'd7) begin
                  remain_d = total_d;
                  buf_d    = '0;
                  mlen_d   = '0;
                  phase_d  = (total_d != 64'd0) ? PH_DATA : PH_DONE;
                end
              end
              PH_DATA: begin
                byte_d = in_byte;
                bit_d  = '0;
                st_d   = S_BITS;
              end
              default: begin
                // idle or finished archive: drop the byte
              end
            endcase
          end
        end
      end

      S_BITS: begin
        if (hit_any) begin
          res = '{valid: 1'b1, sym: hit_sym, status: ST_SYMBOL};
        end else if (cmp.len == LEN_W'(MAX_CODE_LEN)) begin
          res = '{valid: 1'b1, sym: '0, status: ST_NOMATCH};
        end
        // a new result displaces the held one, which needs a free output
        blocked = res.valid && pend_q.valid && !out_free;
        if (!blocked) begin
          remain_d = remain_q - 64'd1;
          if (res.valid) begin
            buf_d  = '0;
            mlen_d = '0;
            if (pend_q.valid) begin
              push      = 1'b1;
              push_item = '{symbol: pend_q.sym, status: pend_q.status, last: 1'b0};
            end
            pend_d = res;
          end else begin
            buf_d  = cmp.bits;
            mlen_d = cmp.len;
          end
          if ((res.valid && res.status == ST_NOMATCH) || remain_q == 64'd1) begin
            phase_d = PH_DONE;
            st_d    = S_FLUSH;
          end else if (bit_q == 3'd7) begin
            st_d = S_FLUSH;
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_q.valid) begin
          st_d = S_IN;
        end else if (out_free) begin
          push         = 1'b1;
          push_item    = '{symbol: pend_q.sym, status: pend_q.status, last: 1'b1};
          pend_d.valid = 1'b0;
          st_d         = S_IN;
        end
      end

      default: begin
        st_d = S_IN;
      end
    endcase

    // output register
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (push) begin
      out_d       = push_item;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (st_q == S_IN);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no held result may linger once a new byte can be taken
  `PCAD_ASSERT_IMPL(a_pend_empty_in, clk_i, rst_ni, st_q == S_IN, !pend_q.valid)
  // buffer never reaches the maximum length without being cleared
  `PCAD_ASSERT_IMPL(a_mlen_bound, clk_i, rst_ni, 1'b1, mlen_q < LEN_W'(MAX_CODE_LEN))
  // results appear only from bit processing or the final hand-over
  `PCAD_ASSERT_NEXT(a_push_src, clk_i, rst_ni, st_q == S_IN, !$rose(out_valid_q))

endmodule

// File: rtl/pcad_cell.sv
// ----------------------------------------------------------------------------
// pcad_cell
// One code table slot: holds length and code bits, flags an exact match.
// ----------------------------------------------------------------------------
module pcad_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      wr_en_i,
  input  logic [pcad_pkg::LEN_W-1:0]  wr_len_i,
  input  logic [pcad_pkg::CODE_W-1:0] wr_bits_i,
  input  pcad_pkg::cmp_t            cmp_i,
  output logic                      hit_o
);
  import pcad_pkg::*;

  logic [LEN_W-1:0]  len_q;
  logic [CODE_W-1:0] bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (clear_i) begin
      len_q <= '0;
    end else if (wr_en_i) begin
      len_q <= wr_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bits_q <= wr_bits_i;
    end
  end

  // absent slots have length zero and never match
  assign hit_o = (len_q != '0) && (len_q == cmp_i.len) && (bits_q == cmp_i.bits);

endmodule

// File: rtl/pcad_cell_array.sv
// ----------------------------------------------------------------------------
// pcad_cell_array
// Row of code table cells with a highest-symbol-wins match encoder.
// ----------------------------------------------------------------------------
module pcad_cell_array (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pcad_pkg::cell_ctl_t      ctl_i,
  input  pcad_pkg::cmp_t           cmp_i,
  output logic                     hit_any_o,
  output logic [pcad_pkg::SYM_W-1:0] hit_sym_o
);
  import pcad_pkg::*;

  logic [TABLE_SLOTS-1:0] hit;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    pcad_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (ctl_i.clear),
      .wr_en_i  (ctl_i.wr && (ctl_i.wr_sym == SYM_W'(g))),
      .wr_len_i (ctl_i.wr_len),
      .wr_bits_i(ctl_i.wr_bits),
      .cmp_i    (cmp_i),
      .hit_o    (hit[g])
    );
  end

  // highest index wins on duplicate codes
  always_comb begin
    hit_sym_o = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (hit[i]) begin
        hit_sym_o = SYM_W'(i);
      end
    end
  end

  assign hit_any_o = |hit;

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the prefix code archive decoder: builds archives
// with tables and coded data, predicts every decoded symbol and error item,
// and compares the outputs in order under random handshake idling.
// ----------------------------------------------------------------------------
module tb_top;
  import pcad_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  prefix_code_archive_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state: a copy of the decoder's parse and match state.
  phase_e      arc_phase;
  logic [7:0]  arc_entries;
  logic [7:0]  arc_sym;
  logic [7:0]  arc_len;
  logic [7:0]  arc_done;
  logic [63:0] arc_shift;
  logic [5:0]  tab_len  [256];
  logic [63:0] tab_bits [256];
  logic [63:0] arc_total;
  logic [2:0]  arc_tidx;
  logic [63:0] arc_used;
  logic [63:0] buf_bits;
  logic [5:0]  buf_len;

  out_item_t decoded_q[$];
  int        fail_count;
  int        idle_in_pct;
  int        idle_out_pct;
  bit        hold_off;
  int        quiet_cycles;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void clear_decoder();
    arc_phase   = PH_IDLE;
    arc_entries = '0;
    arc_sym     = '0;
    arc_len     = '0;
    arc_done    = '0;
    arc_shift   = '0;
    arc_total   = '0;
    arc_tidx    = '0;
    arc_used    = '0;
    buf_bits    = '0;
    buf_len     = '0;
    for (int s = 0; s < 256; s++) begin
      tab_len[s]  = '0;
      tab_bits[s] = '0;
    end
  endfunction

  function automatic void push_result(input logic [7:0] sym, input status_e st);
    out_item_t r;
    r.symbol  = sym;
    r.status  = st;
    r.last    = 1'b0;
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void close_entry();
    arc_entries = arc_entries - 8'd1;
    if (arc_entries != 0) begin
      arc_phase = PH_SYM;
    end else begin
      arc_phase = PH_TOTAL;
      arc_tidx  = '0;
      arc_total = '0;
    end
  endfunction

  // Advance the predictor by one byte; returns the number of items queued.
  function automatic int decode_byte(input in_item_t it);
    int n;
    int found;
    n = 0;
    if (it.start_flag) begin
      for (int s = 0; s < 256; s++) tab_len[s] = '0;
      arc_entries = it.data_byte;
      arc_total   = '0;
      arc_tidx    = '0;
      arc_used    = '0;
      buf_bits    = '0;
      buf_len     = '0;
      arc_phase   = (it.data_byte != 0) ? PH_SYM : PH_TOTAL;
      return 0;
    end
    case (arc_phase)
      PH_SYM: begin
        arc_sym   = it.data_byte;
        arc_phase = PH_LEN;
      end
      PH_LEN: begin
        arc_len   = it.data_byte;
        arc_done  = '0;
        arc_shift = '0;
        if (it.data_byte > MAX_CODE_LEN) begin
          push_result(8'd0, ST_OVERLONG);
          n++;
          arc_phase = PH_DONE;
        end else if (it.data_byte == 0) begin
          tab_len[arc_sym] = '0;
          close_entry();
        end else begin
          arc_phase = PH_BITS;
        end
      end
      PH_BITS: begin
        for (int b = 0; b < 8 && arc_done < arc_len; b++) begin
          arc_shift = {arc_shift[62:0], it.data_byte[7-b]};
          arc_done++;
        end
        if (arc_done >= arc_len) begin
          tab_len[arc_sym]  = arc_len[5:0];
          tab_bits[arc_sym] = arc_shift;
          close_entry();
        end
      end
      PH_TOTAL: begin
        arc_total = arc_total | (64'(it.data_byte) << (8 * arc_tidx));
        arc_tidx++;
        if (arc_tidx == 0) begin
          arc_used  = '0;
          buf_bits  = '0;
          buf_len   = '0;
          arc_phase = (arc_total != 0) ? PH_DATA : PH_DONE;
        end
      end
      PH_DATA: begin
        for (int b = 0; b < 8 && arc_used < arc_total; b++) begin
          buf_bits = {buf_bits[62:0], it.data_byte[7-b]};
          buf_len++;
          arc_used++;
          found = -1;
          for (int s = 0; s < 256; s++)
            if (tab_len[s] != 0 && tab_len[s] == buf_len && tab_bits[s] == buf_bits)
              found = s;
          if (found >= 0) begin
            push_result(8'(found), ST_SYMBOL);
            n++;
            buf_bits = '0;
            buf_len  = '0;
          end else if (buf_len >= MAX_CODE_LEN) begin
            push_result(8'd0, ST_NOMATCH);
            n++;
            arc_phase = PH_DONE;
            break;
          end
        end
        if (arc_phase == PH_DATA && arc_used >= arc_total) arc_phase = PH_DONE;
      end
      default: ;
    endcase
    if (n > 0) decoded_q[decoded_q.size()-1].last = 1'b1;
    return n;
  endfunction

  // Offer one byte; hold it until accepted. Valid drops only while idling.
  task automatic send_byte(input logic [7:0] b, input bit st);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_data_i.data_byte  <= b;
    in_data_i.start_flag <= st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(decode_byte(in_item_t'({b, st})));
    @(negedge clk_i);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Random table of codes drawn from a prefix-free set of fixed-width codes,
  // occasionally with duplicates, removals and repeated symbols.
  logic [31:0] arc_codes[$];

  task automatic send_archive(input bit noisy);
    int cnt, w, nsym, nbits, nbytes;
    logic [7:0] s;
    logic [31:0] c;
    logic [63:0] tot;
    logic [7:0] bitbuf[$];
    arc_codes.delete();
    w    = $urandom_range(1, 5);
    cnt  = $urandom_range(1, (1 << w) > 12 ? 12 : (1 << w));
    send_byte(8'(cnt), 1'b1);
    for (int e = 0; e < cnt; e++) begin
      s = 8'($urandom);
      c = 32'(e) ^ (noisy ? 32'($urandom_range(0, 1)) : 32'd0);
      if (noisy && $urandom_range(9) == 0) begin
        send_byte(s, 1'b0);
        send_byte(8'd0, 1'b0);
        continue;
      end
      arc_codes = {arc_codes, c};
      send_byte(s, 1'b0);
      send_byte(8'(w), 1'b0);
      send_byte(8'(c << (8 - w)), 1'b0);
    end
    // Data: random codes from the table, then random noise when noisy.
    bitbuf.delete();
    nsym = $urandom_range(1, 12);
    nbits = 0;
    for (int k = 0; k < nsym && arc_codes.size() != 0; k++) begin
      c = arc_codes[$urandom_range(arc_codes.size()-1)];
      for (int b = w - 1; b >= 0; b--) begin
        if (nbits % 8 == 0) bitbuf = {bitbuf, 8'd0};
        bitbuf[nbits/8][7 - nbits%8] = c[b];
        nbits++;
      end
    end
    nbytes = bitbuf.size();
    if (noisy) begin
      repeat ($urandom_range(0, 5)) bitbuf = {bitbuf, 8'($urandom)};
      nbits = nbits + $urandom_range(0, 40);
    end
    tot = 64'(nbits);
    if (noisy && $urandom_range(7) == 0) tot = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) send_byte(tot[8*i +: 8], 1'b0);
    foreach (bitbuf[i]) send_byte(bitbuf[i], 1'b0);
    if (nbytes == 0) send_byte(8'($urandom), 1'b0);
  endtask

  // Directed stimulus: {byte, start, check, expect symbol, expect status}.
  // A checked row gives the last item that the byte must raise.
  typedef struct {
    logic [7:0] b;
    bit         st;
    bit         chk;
    logic [7:0] sym;
    status_e    stat;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{8'hA5, 1'b0, 1'b0, 8'd0, ST_SYMBOL},    // ignored before any start
    '{8'h03, 1'b1, 1'b0, 8'd0, ST_SYMBOL},    // three entries
    '{8'hFF, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd1,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'h00, 1'b0, 1'b0, 8'd0, ST_SYMBOL},    // sym 255 code '0'
    '{8'h07, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd1,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'h00, 1'b0, 1'b0, 8'd0, ST_SYMBOL},    // sym 7 duplicate '0'
    '{8'h00, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd32, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'hFF, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'hFF, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'hFF, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'hFE, 1'b0, 1'b0, 8'd0, ST_SYMBOL},    // sym 0, 32-bit code
    '{8'd40, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd0,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd0,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd0,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd0,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd0,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd0,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd0,  1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'h00, 1'b0, 1'b1, 8'hFF, ST_SYMBOL},   // eight symbols of 255
    '{8'h01, 1'b1, 1'b0, 8'd0, ST_SYMBOL},
    '{8'h09, 1'b0, 1'b0, 8'd0, ST_SYMBOL},
    '{8'd33, 1'b0, 1'b1, 8'd0, ST_OVERLONG}   // overlong: one result
  };

  initial begin
    fail_count   = 0;
    hold_off     = 1'b0;
    idle_in_pct  = 18;
    idle_out_pct = 82;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    rst_ni       = 1'b0;
    clear_decoder();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Long receiver hold-off while the sender keeps offering items: the
    // eight symbols of one byte fill the output and stall the input.
    hold_off = 1'b1;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].b, directed_rows[i].st);
      if (directed_rows[i].chk) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("directed item count", 0, 1);
        end else begin
          if (decoded_q[$].symbol != directed_rows[i].sym)
            report_mismatch("directed symbol", decoded_q[$].symbol, directed_rows[i].sym);
          if (decoded_q[$].status != directed_rows[i].stat)
            report_mismatch("directed status", decoded_q[$].status, directed_rows[i].stat);
        end
      end
    end
    hold_off = 1'b0;
    // Count of zero, total of zero, then ignored bytes.
    send_byte(8'd0, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'd0, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Empty table with data: no match after the maximum length.
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b0);
    for (int i = 0; i < 7; i++) send_byte(8'd0, 1'b0);
    for (int i = 0; i < 5; i++) send_byte(8'h5A, 1'b0);
    drain_wait();

    for (int ph = 0; ph < 3; ph++) begin
      idle_in_pct  = (ph == 0) ? 18 : (ph == 1) ? 82 : 0;
      idle_out_pct = (ph == 0) ? 82 : (ph == 1) ? 18 : 0;
      repeat (5) send_archive($urandom_range(3) == 0);
      if ($urandom_range(1)) drain_wait();
      repeat (4) send_byte(8'($urandom), 1'($urandom_range(7) == 0));
    end
    drain_wait();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random ready, with a long counted hold-off when asked.
  initial begin
    int held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off && held < 300) begin
        held++;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_out_pct);
      end
    end
  end

  // Compare each accepted item with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected item", out_data_o.symbol, -1);
      end else begin
        want = decoded_q.pop_front();
        if (out_data_o.symbol != want.symbol)
          report_mismatch("symbol", out_data_o.symbol, want.symbol);
        if (out_data_o.status != want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.last != want.last)
          report_mismatch("last", out_data_o.last, want.last);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial quiet_cycles = 0;

endmodule
